// File: sv/bucketed_hash_table_assert.svh
// Assertion macros used by the top level of the bucketed hash table.
`ifndef BUCKETED_HASH_TABLE_ASSERT_SVH
`define BUCKETED_HASH_TABLE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bht_pkg.sv
// Shared types, codes and default sizes of the bucketed hash table.
package bht_pkg;

  localparam int unsigned OP_W          = 2;
  localparam int unsigned KEY_W         = 16;
  localparam int unsigned HANDLE_W      = 16;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned BUCKETS_DEF   = 16;
  localparam int unsigned SLOTS_DEF     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } bht_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_MISSING = 2'd2
  } bht_status_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_ADDR  = 5'b01000,
    S_EXEC  = 5'b10000
  } bht_state_e;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } bht_slot_t;

  typedef struct packed {
    logic clr_we;
    logic load_in;
    logic hash_en;
    logic rd_en;
    logic exec_en;
  } bht_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } bht_sts_t;

endpackage

// File: sv/bht_ctrl.sv
// Sequencing state machine of the bucketed hash table.
module bht_ctrl
  import bht_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bht_sts_t sts_i,
  output bht_cmd_t cmd_o
);

  bht_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash_en = 1'b1;
        state_d       = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec_en = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/bht_datapath.sv
// Hashing, bucket memory, slot compare and result register of the hash table.
module bht_datapath
  import bht_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned SLOTS   = SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bht_cmd_t            cmd_i,
  output bht_sts_t            sts_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [KEY_W-1:0]    key_id_i,
  input  logic [HANDLE_W-1:0] record_handle_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] found_handle_o
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned HS = KEY_W + BW;
  localparam longint unsigned MREC = (longint'(1) << HS) / BUCKETS;
  localparam int unsigned MW = $clog2(MREC + 1);
  localparam int unsigned PW = KEY_W + MW;
  localparam int unsigned QW = PW - HS;
  localparam int unsigned QBW = KEY_W + BW + 1;

  bht_slot_t [SLOTS-1:0] mem [BUCKETS];

  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [PW-1:0]       prod_q;
  logic [KEY_W-1:0]    qb_q;
  logic [BW-1:0]       bucket_q;
  logic [BW-1:0]       clr_cnt_q;
  bht_slot_t [SLOTS-1:0] rdata_q;

  logic [QW-1:0]       quot;
  logic [QBW-1:0]      qb_full;
  logic [KEY_W-1:0]    rem0;
  logic [KEY_W-1:0]    rem1;
  logic [BW-1:0]       bucket_d;

  logic                any_match;
  logic                any_empty;
  logic [SW-1:0]       match_idx;
  logic [SW-1:0]       empty_idx;
  bht_slot_t [SLOTS-1:0] upd_word;
  logic                upd_we;
  logic [STATUS_W-1:0] status_d;
  logic [HANDLE_W-1:0] found_d;

  logic                mem_we;
  logic [BW-1:0]       mem_waddr;
  bht_slot_t [SLOTS-1:0] mem_wdata;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [HANDLE_W-1:0] found_q;

  // The bucket is the key modulo BUCKETS, taken by a reciprocal multiply
  // whose quotient is at most one too small, then one correcting subtract.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q     <= operation_i;
      key_q    <= key_id_i;
      handle_q <= record_handle_i;
      prod_q   <= PW'(key_id_i) * PW'(MREC);
    end
    if (cmd_i.hash_en) begin
      qb_q <= qb_full[KEY_W-1:0];
    end
    if (cmd_i.rd_en) begin
      bucket_q <= bucket_d;
    end
  end

  assign quot    = prod_q[PW-1:HS];
  assign qb_full = QBW'(quot) * QBW'(BUCKETS);
  assign rem0    = key_q - qb_q;
  assign rem1    = ({1'b0, rem0} >= (KEY_W + 1)'(BUCKETS)) ? rem0 - KEY_W'(BUCKETS) : rem0;
  assign bucket_d = rem1[BW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clr_done = (clr_cnt_q == BW'(BUCKETS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[bucket_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    any_match = 1'b0;
    any_empty = 1'b0;
    match_idx = '0;
    empty_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (rdata_q[s].valid && (rdata_q[s].key == key_q)) begin
        any_match = 1'b1;
        match_idx = SW'(s);
      end
      if (!rdata_q[s].valid) begin
        any_empty = 1'b1;
        empty_idx = SW'(s);
      end
    end
  end

  always_comb begin
    upd_word = rdata_q;
    upd_we   = 1'b0;
    status_d = STS_MISSING;
    found_d  = '0;
    case (op_q)
      OP_INSERT: begin
        if (any_empty) begin
          upd_word[empty_idx].valid  = 1'b1;
          upd_word[empty_idx].key    = key_q;
          upd_word[empty_idx].handle = handle_q;
          upd_we   = 1'b1;
          status_d = STS_OK;
        end else begin
          status_d = STS_FULL;
        end
      end
      OP_REMOVE: begin
        if (any_match) begin
          upd_word[match_idx].valid = 1'b0;
          upd_we   = 1'b1;
          status_d = STS_OK;
        end
      end
      OP_LOOKUP: begin
        if (any_match) begin
          found_d  = rdata_q[match_idx].handle;
          status_d = STS_OK;
        end
      end
      default: begin
        status_d = STS_MISSING;
      end
    endcase
  end

  assign mem_we    = cmd_i.clr_we | (cmd_i.exec_en & upd_we);
  assign mem_waddr = cmd_i.clr_we ? clr_cnt_q : bucket_q;
  assign mem_wdata = cmd_i.clr_we ? '0 : upd_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_en) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_handle_o = found_q;

endmodule

// File: sv/bucketed_hash_table.sv
// Top level of the bucketed hash table.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   operation_i, key_id_i, record_handle_i
//   out      output     out_valid_o / out_stall_i status_o, found_handle_o
//
// The reciprocal product is registered at the transfer; the HASH state then registers the
// quotient times BUCKETS, the ADDR state takes the remainder and reads the bucket, and the
// EXEC state compares and writes the bucket back, waiting while a stalled result is held.
// The controller holds one item at a time: a new item is taken once the last is executed.
// After reset a clearing pass writes every bucket, one a cycle.
// A stalled result waits in the output register while the next item is taken.
`include "bucketed_hash_table_assert.svh"

module bucketed_hash_table
  import bht_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned SLOTS   = SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [KEY_W-1:0]    key_id_i,
  input  logic [HANDLE_W-1:0] record_handle_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] found_handle_o
);

  bht_cmd_t cmd;
  bht_sts_t sts;

  bht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bht_datapath #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .key_id_i        (key_id_i),
    .record_handle_i (record_handle_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .found_handle_o  (found_handle_o)
  );

  `BHT_ASSERT_NEXT(a_accept_hashes, in_valid_i && !in_stall_o, cmd.hash_en, "transfer not hashed")
  `BHT_ASSERT_SAME(a_fail_zero, out_valid_o && (status_o != STS_OK), found_handle_o == '0, "handle on failure")
  `BHT_ASSERT_SAME(a_rise_exec, $rose(out_valid_o), $past(cmd.exec_en), "result without execution")

endmodule
